### rtl/core/wola_pkg.sv
// package: types, constants and helpers for the weighted overlap-add normalizer
package wola_pkg;

	localparam int WINDOW_FRAMES = 262144;
	localparam int SLOT_W = $clog2(WINDOW_FRAMES);
	localparam int EXT_W = SLOT_W + 1;
	localparam int POS_W = 40;
	localparam int SAMP_W = 16;
	localparam int WIN_W = 17;
	localparam int ACC_W = 40;
	localparam int WSUM_W = 24;
	localparam int ENTRY_W = 2 * ACC_W + WSUM_W;
	// divider: 42-bit dividend (2*mag+ws), 25-bit divisor, quotient saturated to a 16-bit result
	localparam int DVD_W = ACC_W + 2;
	localparam int DVS_W = WSUM_W + 1;
	localparam int QCNT_W = $clog2(DVD_W + 1);
	localparam int CLR_W = SLOT_W + 1;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BEHIND = 2'd1;
	localparam logic [1:0] ST_BEYOND = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	localparam logic FUNC_ADD = 1'b0;
	localparam logic FUNC_POP = 1'b1;

	localparam logic [WIN_W-1:0] WEIGHT_ONE = WIN_W'(65536);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_WAIT,
		S_ADD,
		S_DIV_L,
		S_DIV_R,
		S_WRITE,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [ACC_W-1:0] left_sum;
		logic [ACC_W-1:0] right_sum;
		logic [WSUM_W-1:0] weight_sum;
	} entry_t;

	typedef struct packed {
		logic start;
		logic sel_right;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	// saturating accumulate of one product into a 40-bit signed sum
	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
			input logic signed [SAMP_W+WIN_W:0] p);
		logic signed [ACC_W:0] s;
		s = $signed({a[ACC_W-1], a}) + (ACC_W+1)'(p);
		if (s[ACC_W] != s[ACC_W-1])
			return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		return s[ACC_W-1:0];
	endfunction

endpackage

### rtl/core/wola_stream_if.sv
// valid/ready channel interfaces for input and result beats
interface wola_in_if;
	logic valid;
	logic ready;
	logic func;
	logic [39:0] position;
	logic signed [15:0] left_in;
	logic signed [15:0] right_in;
	logic [16:0] weight;
	modport source (output valid, func, position, left_in, right_in, weight, input ready);
	modport sink (input valid, func, position, left_in, right_in, weight, output ready);
endinterface

interface wola_out_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [39:0] frame_index;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;
	modport source (output valid, status, frame_index, left_out, right_out, input ready);
	modport sink (input valid, status, frame_index, left_out, right_out, output ready);
endinterface

### rtl/core/weighted_overlap_add_normalizer_top.sv
// top level of the weighted overlap-add normalizer
// One item at a time. After reset the ring store is cleared, one entry per cycle, before
// the first item is taken. An add runs through store read, accumulate, write back and
// result. A pop that releases a frame runs the shared 42-step serial divider twice, once
// per channel; a rejected add or pop goes from the store read straight to the result. A
// result waits in an output register until taken, and the next item is accepted once it
// is gone.
module weighted_overlap_add_normalizer_top (
	input logic        clk,
	input logic        arst_n,
	wola_in_if.sink    in_ch,
	wola_out_if.source out_ch
);
	import wola_pkg::*;

	div_ctl_t div_ctl;
	div_sts_t div_sts;
	logic [15:0] div_result;
	logic [ACC_W-1:0] div_acc;
	logic [WSUM_W-1:0] div_ws;

	wola_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.div_ctl(div_ctl), .div_sts(div_sts), .div_result(div_result),
		.div_acc(div_acc), .div_ws(div_ws)
	);

	wola_div u_div (
		.clk(clk), .arst_n(arst_n), .ctl(div_ctl), .acc(div_acc), .ws(div_ws),
		.sts(div_sts), .result(div_result)
	);
endmodule

### rtl/core/wola_ram.sv
// generic single-port ram with registered read
module wola_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

### rtl/core/wola_div.sv
// shared restoring divider: rounded, saturated normalization of one sum
module wola_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  wola_pkg::div_ctl_t       ctl,
	input  logic [wola_pkg::ACC_W-1:0]  acc,
	input  logic [wola_pkg::WSUM_W-1:0] ws,
	output wola_pkg::div_sts_t       sts,
	output logic [15:0]              result
);
	import wola_pkg::*;

	logic [DVD_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [QCNT_W-1:0] cnt_q;
	logic neg_q, zero_q, busy_q, done_q;
	logic [ACC_W-1:0] mag;
	logic [DVD_W:0] trial;
	logic [DVD_W-1:0] shifted;

	assign mag = acc[ACC_W-1] ? (~acc + 1'b1) : acc;
	assign shifted = {rem_q[DVD_W-2:0], dvd_q[DVD_W-1]};
	assign trial = {1'b0, shifted} - (DVD_W+1)'(dvs_q);

	// one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !ctl.start && (cnt_q == QCNT_W'(1));
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= QCNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == QCNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= DVD_W'({mag, 1'b0}) + DVD_W'(ws);
			dvs_q <= {ws, 1'b0};
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= acc[ACC_W-1];
			zero_q <= (ws == '0);
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			if (!trial[DVD_W]) begin
				rem_q <= trial[DVD_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	// sign, saturation and zero weight
	always_comb begin
		if (zero_q)
			result = '0;
		else if (neg_q)
			result = (quo_q > DVD_W'(32768)) ? 16'h8000 : 16'(~quo_q + 1'b1);
		else
			result = (quo_q > DVD_W'(32767)) ? 16'h7fff : quo_q[15:0];
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
endmodule

### rtl/core/wola_ctrl.sv
// sequencer: decode, ring store access, accumulate, release and result register
module wola_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	wola_in_if.sink            in_ch,
	wola_out_if.source         out_ch,
	output wola_pkg::div_ctl_t div_ctl,
	input  wola_pkg::div_sts_t div_sts,
	input  logic [15:0]        div_result,
	output logic [wola_pkg::ACC_W-1:0]  div_acc,
	output logic [wola_pkg::WSUM_W-1:0] div_ws
);
	import wola_pkg::*;

	state_t state_q, state_d;
	logic [CLR_W-1:0] clr_q;
	logic [POS_W-1:0] base_q;
	logic [EXT_W-1:0] ext_q;
	logic func_q;
	logic [POS_W-1:0] pos_q;
	logic signed [SAMP_W-1:0] l_q, r_q;
	logic [WIN_W-1:0] w_q;
	entry_t ent_q;
	logic [1:0] status_q;
	logic [POS_W-1:0] index_q;
	logic [15:0] lo_q, ro_q;
	logic valid_q;

	logic [POS_W-1:0] off;
	logic behind, beyond, pop_ok;
	logic ram_we;
	logic [SLOT_W-1:0] ram_addr;
	entry_t ram_wdata, ram_rdata;
	logic signed [SAMP_W+WIN_W:0] pl, pr;
	logic [WSUM_W:0] wsum;

	assign off = pos_q - base_q;
	assign behind = pos_q < base_q;
	assign beyond = off >= POS_W'(WINDOW_FRAMES);
	assign pop_ok = (pos_q > base_q) && (ext_q != '0);

	wola_ram #(.WIDTH(ENTRY_W), .DEPTH(WINDOW_FRAMES)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr),
		.wdata(ram_wdata), .rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == CLR_W'(WINDOW_FRAMES - 1)) state_d = S_IDLE;
			S_IDLE:  if (in_ch.valid && !valid_q) state_d = S_READ;
			S_READ: begin
				if (func_q == FUNC_ADD)
					state_d = (behind || beyond) ? S_OUT : S_WAIT;
				else
					state_d = pop_ok ? S_WAIT : S_OUT;
			end
			S_WAIT:  state_d = (func_q == FUNC_ADD) ? S_ADD : S_DIV_L;
			S_ADD:   state_d = S_WRITE;
			S_DIV_L: if (div_sts.done) state_d = S_DIV_R;
			S_DIV_R: if (div_sts.done) state_d = S_WRITE;
			S_WRITE: state_d = S_OUT;
			S_OUT:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ch.ready = (state_q == S_IDLE) && !valid_q;
		ram_we = 1'b0;
		ram_addr = (func_q == FUNC_ADD) ? pos_q[SLOT_W-1:0] : base_q[SLOT_W-1:0];
		ram_wdata = ent_q;
		div_ctl.start = 1'b0;
		div_ctl.sel_right = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_addr = clr_q[SLOT_W-1:0];
				ram_wdata = '0;
			end
			S_WAIT:  div_ctl.start = (func_q == FUNC_POP);
			S_DIV_L: begin
				div_ctl.start = div_sts.done;
				div_ctl.sel_right = div_sts.done;
			end
			S_DIV_R: div_ctl.sel_right = 1'b1;
			S_WRITE: begin
				ram_we = 1'b1;
				if (func_q == FUNC_POP) ram_wdata = '0;
			end
			default: ;
		endcase
	end

	assign div_acc = div_ctl.sel_right ? ram_rdata.right_sum : ram_rdata.left_sum;
	assign div_ws = ram_rdata.weight_sum;

	assign pl = $signed(l_q) * $signed({1'b0, w_q});
	assign pr = $signed(r_q) * $signed({1'b0, w_q});
	assign wsum = {1'b0, ram_rdata.weight_sum} + (WSUM_W+1)'(w_q);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			base_q <= '0;
			ext_q <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (out_ch.valid && out_ch.ready) valid_q <= 1'b0;
			if (state_q == S_OUT) valid_q <= 1'b1;
			if (state_q == S_WRITE) begin
				if (func_q == FUNC_ADD) begin
					if (off[EXT_W-1:0] + 1'b1 > ext_q) ext_q <= off[EXT_W-1:0] + 1'b1;
				end else begin
					base_q <= base_q + 1'b1;
					ext_q <= ext_q - 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			func_q <= in_ch.func;
			pos_q <= in_ch.position;
			l_q <= in_ch.left_in;
			r_q <= in_ch.right_in;
			w_q <= (in_ch.weight > WEIGHT_ONE) ? WEIGHT_ONE : in_ch.weight;
		end
		if (state_q == S_READ) begin
			lo_q <= '0;
			ro_q <= '0;
			if (func_q == FUNC_ADD) begin
				index_q <= pos_q;
				status_q <= behind ? ST_BEHIND : (beyond ? ST_BEYOND : ST_OK);
			end else begin
				index_q <= base_q;
				status_q <= pop_ok ? ST_OK : ST_EMPTY;
			end
		end
		if (state_q == S_ADD) begin
			ent_q.left_sum <= sat_add(ram_rdata.left_sum, pl);
			ent_q.right_sum <= sat_add(ram_rdata.right_sum, pr);
			ent_q.weight_sum <= wsum[WSUM_W] ? {WSUM_W{1'b1}} : wsum[WSUM_W-1:0];
		end
		if (state_q == S_DIV_L && div_sts.done) lo_q <= div_result;
		if (state_q == S_DIV_R && div_sts.done) ro_q <= div_result;
	end

	assign out_ch.valid = valid_q;
	assign out_ch.status = status_q;
	assign out_ch.frame_index = index_q;
	assign out_ch.left_out = lo_q;
	assign out_ch.right_out = ro_q;
endmodule

### tb/sv/tb_weighted_overlap_add_normalizer_top.sv
// testbench for the weighted overlap-add normalizer: directed and random beats vs a predictor
`timescale 1ns / 100ps

module tb_weighted_overlap_add_normalizer_top;
	import wola_pkg::*;

	typedef struct packed {
		logic [1:0] status;
		logic [POS_W-1:0] frame_index;
		logic signed [SAMP_W-1:0] left_out;
		logic signed [SAMP_W-1:0] right_out;
	} frame_result_t;

	logic clk;
	logic arst_n;

	wola_in_if in_ch();
	wola_out_if out_ch();

	weighted_overlap_add_normalizer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// predictor state, sparse: only touched slots are stored
	longint left_acc[int];
	longint right_acc[int];
	int unsigned wsum_acc[int];
	logic [POS_W-1:0] base_frame;
	int unsigned filled;

	frame_result_t expected_frames[$];
	int mismatches;
	int checked;
	int n_adds;
	int n_pops;
	int n_released;

	localparam longint ACC_HI = 64'sd549755813887;
	localparam longint ACC_LO = -64'sd549755813888;
	localparam longint WIN = WINDOW_FRAMES;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// rounded, saturated quotient of a channel sum by its weight sum
	function automatic logic signed [15:0] normalize_sample(longint acc, int unsigned ws);
		longint unsigned mag;
		longint unsigned q;
		if (ws == 0)
			return 16'sd0;
		mag = (acc < 0) ? longint'(-acc) : longint'(acc);
		q = (2 * mag + ws) / (2 * longint'(ws));
		if (acc < 0) begin
			if (q > 32768)
				return -16'sd32768;
			return 16'(-longint'(q));
		end
		if (q > 32767)
			return 16'sd32767;
		return 16'(q);
	endfunction

	function automatic longint clamp_acc(longint v);
		if (v > ACC_HI)
			return ACC_HI;
		if (v < ACC_LO)
			return ACC_LO;
		return v;
	endfunction

	// compute the result of one beat and update the predictor state
	function automatic frame_result_t predict_frame(logic fn, logic [39:0] pos,
			logic signed [15:0] l, logic signed [15:0] r, logic [16:0] w);
		frame_result_t res;
		int slot;
		longint unsigned off;
		int unsigned wt;
		longint unsigned ws;
		res.status = ST_OK;
		res.frame_index = pos;
		res.left_out = '0;
		res.right_out = '0;
		if (fn == FUNC_ADD) begin
			if (pos < base_frame) begin
				res.status = ST_BEHIND;
			end else if (pos - base_frame >= WIN) begin
				res.status = ST_BEYOND;
			end else begin
				off = pos - base_frame;
				slot = int'(pos % WIN);
				wt = (w > WEIGHT_ONE) ? 65536 : w;
				if (!left_acc.exists(slot)) begin
					left_acc[slot] = 0;
					right_acc[slot] = 0;
					wsum_acc[slot] = 0;
				end
				left_acc[slot] = clamp_acc(left_acc[slot] + longint'(l) * wt);
				right_acc[slot] = clamp_acc(right_acc[slot] + longint'(r) * wt);
				ws = wsum_acc[slot] + wt;
				wsum_acc[slot] = (ws > 24'hFFFFFF) ? 24'hFFFFFF : ws;
				if (off + 1 > filled)
					filled = 32'(off + 1);
			end
		end else begin
			res.frame_index = base_frame;
			if (pos <= base_frame || filled == 0) begin
				res.status = ST_EMPTY;
			end else begin
				slot = int'(base_frame % WIN);
				if (left_acc.exists(slot)) begin
					res.left_out = normalize_sample(left_acc[slot], wsum_acc[slot]);
					res.right_out = normalize_sample(right_acc[slot], wsum_acc[slot]);
					left_acc.delete(slot);
					right_acc.delete(slot);
					wsum_acc.delete(slot);
				end
				base_frame = base_frame + 1;
				filled--;
				n_released++;
			end
		end
		return res;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// send one beat, predict at acceptance; valid stays high across back-to-back beats
	task automatic send_frame(logic fn, logic [39:0] pos, logic signed [15:0] l,
			logic signed [15:0] r, logic [16:0] w);
		int g;
		frame_result_t pred;
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func <= fn;
		in_ch.position <= pos;
		in_ch.left_in <= l;
		in_ch.right_in <= r;
		in_ch.weight <= w;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		pred = predict_frame(fn, pos, l, r, w);
		expected_frames.insert(expected_frames.size(), pred);
		if (fn == FUNC_ADD)
			n_adds++;
		else
			n_pops++;
	endtask

	function automatic logic [16:0] rand_weight();
		int p;
		p = $urandom_range(0, 9);
		if (p == 0)
			return 17'($urandom_range(65537, 131071));
		if (p == 1)
			return 17'd65536;
		if (p == 2)
			return 17'd0;
		return 17'($urandom_range(0, 65536));
	endfunction

	// random result-side stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 99) < 94)
				out_ch.ready <= ($urandom_range(0, 9) < 7);
			else
				out_ch.ready <= 1'b0;
		end
	end

	// result checker
	always @(posedge clk) begin
		frame_result_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			checked++;
			if (expected_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: status %0d index %0d",
						out_ch.status, out_ch.frame_index);
			end else begin
				exp_r = expected_frames.pop_front();
				if (out_ch.status !== exp_r.status || out_ch.frame_index !== exp_r.frame_index
						|| out_ch.left_out !== exp_r.left_out
						|| out_ch.right_out !== exp_r.right_out) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st %0d idx %0d l %0d r %0d, got st %0d idx %0d l %0d r %0d",
							exp_r.status, exp_r.frame_index, exp_r.left_out, exp_r.right_out,
							out_ch.status, out_ch.frame_index, out_ch.left_out,
							out_ch.right_out);
				end
			end
		end
	end

	// directed: field extremes, window edges and every status
	task automatic test_directed();
		send_frame(FUNC_POP, 40'd5, 0, 0, 0);
		send_frame(FUNC_ADD, 40'd0, 16'sh7FFF, -16'sd32768, 17'd65536);
		send_frame(FUNC_ADD, 40'd0, 16'sh7FFF, -16'sd32768, 17'h1FFFF);
		send_frame(FUNC_ADD, 40'd1, -16'sd1, 16'sd1, 17'd3);
		send_frame(FUNC_ADD, 40'd2, 16'sd100, 16'sd100, 17'd0);
		send_frame(FUNC_ADD, 40'd3, 16'sd5, -16'sd5, 17'd2);
		send_frame(FUNC_ADD, 40'(WINDOW_FRAMES - 1), 16'sd1234, -16'sd4321, 17'd77);
		send_frame(FUNC_ADD, 40'(WINDOW_FRAMES), 16'sd1, 16'sd1, 17'd1);
		send_frame(FUNC_ADD, 40'hFF_FFFF_FFFF, 16'sd1, 16'sd1, 17'd1);
		send_frame(FUNC_POP, 40'd0, 0, 0, 0);
		send_frame(FUNC_POP, 40'd1, 0, 0, 0);
		send_frame(FUNC_ADD, 40'd0, 16'sd9, 16'sd9, 17'd9);
		send_frame(FUNC_POP, 40'hFF_FFFF_FFFF, 0, 0, 0);
		send_frame(FUNC_POP, 40'hFF_FFFF_FFFF, 0, 0, 0);
		send_frame(FUNC_POP, 40'd10, 0, 0, 0);
		// repeated full-scale adds on one frame, well within the accumulator range
		repeat (8) send_frame(FUNC_ADD, 40'd10, 16'sh7FFF, -16'sd32768, 17'd65536);
		send_frame(FUNC_POP, 40'd100, 0, 0, 0);
	endtask

	// random: well-formed overlap streams with some noise
	task automatic test_random_stream(int total);
		int k;
		int p;
		logic [39:0] pos;
		for (k = 0; k < total; k++) begin
			p = $urandom_range(0, 99);
			if (p < 55) begin
				pos = base_frame + $urandom_range(0, 12);
				send_frame(FUNC_ADD, pos, 16'($urandom), 16'($urandom), rand_weight());
			end else if (p < 85) begin
				send_frame(FUNC_POP, base_frame + $urandom_range(0, 6), 16'($urandom),
					16'($urandom), 17'($urandom));
			end else if (p < 90) begin
				send_frame(FUNC_ADD, base_frame - $urandom_range(1, 50), 16'($urandom),
					16'($urandom), rand_weight());
			end else if (p < 95) begin
				send_frame(FUNC_ADD, 40'(base_frame + WIN + $urandom_range(0, 3)),
					16'($urandom), 16'($urandom), rand_weight());
			end else begin
				pos = 40'({$urandom, $urandom});
				send_frame(FUNC_ADD, pos, 16'($urandom), 16'($urandom), rand_weight());
			end
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.func = FUNC_ADD;
		in_ch.position = '0;
		in_ch.left_in = '0;
		in_ch.right_in = '0;
		in_ch.weight = '0;
		mismatches = 0;
		checked = 0;
		n_adds = 0;
		n_pops = 0;
		n_released = 0;
		base_frame = '0;
		filled = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_stream(1280);
		in_ch.valid <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d adds and %0d pops, %0d frames released, %0d results checked",
			n_adds, n_pops, n_released, checked);
		if (mismatches == 0 && expected_frames.size() == 0) begin
			$display("weighted_overlap_add_normalizer_top test passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("weighted_overlap_add_normalizer_top test failed");
		end
		$finish;
	end

	// run limit: clearing pass plus slow pops under heavy stalls
	initial begin
		#20ms;
		$display("weighted_overlap_add_normalizer_top test failed");
		$finish;
	end

endmodule

### sim.f
rtl/core/wola_pkg.sv
rtl/core/wola_stream_if.sv
rtl/core/wola_ram.sv
rtl/core/wola_div.sv
rtl/core/wola_ctrl.sv
rtl/core/weighted_overlap_add_normalizer_top.sv
tb/sv/tb_weighted_overlap_add_normalizer_top.sv
